// ----- hdl/dtt_pkg.sv -----
// Package with the constants, codes and payload types of the deadline timer table.
package dtt_pkg;
  localparam int SLOTS = 32;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int TIME_BITS = 32;
  localparam int IN_DATA_BITS = 72;
  localparam int OUT_DATA_BITS = 40;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_FIND = 3'd2;
  localparam logic [2:0] OP_EXPIRE = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_KEPT = 3'd1;
  localparam logic [2:0] ST_DELETED = 3'd2;
  localparam logic [2:0] ST_NOT_ARMED = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_EXPIRED = 3'd5;
  localparam logic [2:0] ST_CANCELLED = 3'd6;
  localparam logic [2:0] ST_NONE = 3'd7;

  localparam logic [15:0] LAZY_RESET = 16'd300;
  localparam int MAX_RESULTS = 32;

  typedef logic [TIME_BITS-1:0] time_t;
endpackage

// ----- hdl/dtt_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/deadline_timer_table_top.sv -----
// Top level of the deadline timer table: command decode, scan sequencer and result register.
// Add and delete read the slot, then decide and write back. Find takes one full scan;
// expire and cancel take one scan per removed timer plus one final scan, because
// deadlines and cancelable flags sit in one single-port memory read one slot per cycle
// while the armed flags are flip-flops cleared at reset.
// A removed timer is held back until the following scan shows whether it is the final
// one, so its beat leaves with the right last flag.
// A result waits in the output register; the sequencer stalls at the end of a scan while it is not taken.
module deadline_timer_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], slot[7:3], delay_ms[38:8], cancel_ok[39], now_ms[71:40]
  input  logic [dtt_pkg::IN_DATA_BITS-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], slot_out[7:3], wait_ms[38:8], no_timer[39]
  output logic [dtt_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import dtt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_UPD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [15:0] lazy_r;
  logic [SLOTS-1:0] armed_r, armed_nxt;
  logic [2:0] op_r;
  logic [4:0] slot_r;
  logic [30:0] delay_r;
  logic cok_r;
  time_t now_r;
  logic [SLOT_BITS:0] idx_r, idx_nxt;
  logic rd_v_r;
  logic [SLOT_BITS-1:0] rd_i_r;
  logic best_v_r, best_v_nxt;
  logic [SLOT_BITS-1:0] best_i_r, best_i_nxt;
  time_t best_k_r, best_k_nxt;
  logic best_c_r, best_c_nxt;
  logic [SLOT_BITS-1:0] pend_i_r, pend_i_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic ov_r, ov_nxt;
  logic [OUT_DATA_BITS-1:0] od_r, od_nxt;
  logic ol_r, ol_nxt;

  logic ram_we;
  logic [SLOT_BITS-1:0] ram_addr;
  logic [TIME_BITS:0] ram_wd, ram_rd;

  dtt_ram #(.WIDTH(TIME_BITS + 1), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

  time_t new_key, diff, rkey, mag, wdiff;
  logic slot_ok;
  logic [SLOT_BITS-1:0] slot_i;
  logic found;

  function automatic logic [OUT_DATA_BITS-1:0] pack(input logic [2:0] st, input logic [4:0] sl,
                                                    input logic [30:0] w, input logic nt);
    pack = {nt, w, sl, st};
  endfunction

  always_comb begin
    state_nxt = state_r;
    armed_nxt = armed_r;
    idx_nxt = idx_r;
    best_v_nxt = best_v_r;
    best_i_nxt = best_i_r;
    best_k_nxt = best_k_r;
    best_c_nxt = best_c_r;
    pend_i_nxt = pend_i_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    ol_nxt = ol_r;
    ram_we = 1'b0;
    ram_wd = '0;
    slot_ok = ({1'b0, slot_r} < 6'(SLOTS));
    slot_i = slot_r[SLOT_BITS-1:0];
    ram_addr = (state_r == S_SCAN) ? idx_r[SLOT_BITS-1:0] : slot_i;
    new_key = now_r + TIME_BITS'(delay_r);
    diff = new_key - ram_rd[TIME_BITS-1:0];
    mag = diff[TIME_BITS-1] ? (~diff + 1'b1) : diff;
    if (diff == {1'b1, {(TIME_BITS-1){1'b0}}}) mag = diff;
    rkey = (ram_rd[TIME_BITS-1:0] - now_r) ^ {1'b1, {(TIME_BITS-1){1'b0}}};
    wdiff = best_k_r ^ {1'b1, {(TIME_BITS-1){1'b0}}};
    found = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (op_r == OP_ADD || op_r == OP_DELETE) begin
          state_nxt = S_UPD;
        end else if (op_r == OP_FIND || op_r == OP_EXPIRE || op_r == OP_CANCEL) begin
          state_nxt = S_SCAN;
          idx_nxt = '0;
          best_v_nxt = 1'b0;
        end else begin
          od_nxt = pack(ST_NONE, 5'd0, 31'd0, 1'b0);
          ol_nxt = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_UPD: begin
        ol_nxt = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_EMIT;
        if (!slot_ok) begin
          od_nxt = pack(ST_NOT_ARMED, slot_r, 31'd0, 1'b0);
        end else if (op_r == OP_DELETE) begin
          od_nxt = pack(armed_r[slot_i] ? ST_DELETED : ST_NOT_ARMED, slot_r, 31'd0, 1'b0);
          armed_nxt[slot_i] = 1'b0;
        end else begin
          ram_we = 1'b1;
          if (armed_r[slot_i] && (mag < TIME_BITS'(lazy_r))) begin
            ram_wd = {cok_r, ram_rd[TIME_BITS-1:0]};
            od_nxt = pack(ST_KEPT, slot_r, 31'd0, 1'b0);
          end else begin
            ram_wd = {cok_r, new_key};
            armed_nxt[slot_i] = 1'b1;
            od_nxt = pack(ST_ADDED, slot_r, 31'd0, 1'b0);
          end
        end
      end
      S_SCAN: begin
        // Address idx is issued now; data of the previous slot arrives this cycle.
        if (rd_v_r && armed_r[rd_i_r] && (!best_v_r || rkey < best_k_r)) begin
          best_v_nxt = 1'b1;
          best_i_nxt = rd_i_r;
          best_k_nxt = rkey;
          best_c_nxt = ram_rd[TIME_BITS];
        end
        if (idx_r == (SLOT_BITS+1)'(SLOTS)) state_nxt = S_DONE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          if (op_r == OP_FIND) begin
            od_nxt = pack(ST_WAIT, 5'd0,
                          (best_v_r && !wdiff[TIME_BITS-1])
                            ? ((wdiff > 32'h7FFFFFFF) ? 31'h7FFFFFFF : wdiff[30:0]) : 31'd0,
                          !best_v_r);
            ol_nxt = 1'b1;
            ov_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            found = best_v_r && (cnt_r != 6'(MAX_RESULTS)) &&
                    ((op_r == OP_EXPIRE) ? (wdiff == '0 || wdiff[TIME_BITS-1]) : best_c_r);
            if (found) begin
              armed_nxt[best_i_r] = 1'b0;
              cnt_nxt = cnt_r + 1'b1;
              pend_i_nxt = best_i_r;
              // Another removal follows, so the one held back is not the final one.
              if (cnt_r != '0) begin
                od_nxt = pack((op_r == OP_EXPIRE) ? ST_EXPIRED : ST_CANCELLED,
                              5'(pend_i_r), 31'd0, 1'b0);
                ol_nxt = 1'b0;
                ov_nxt = 1'b1;
              end
              state_nxt = S_SCAN;
              idx_nxt = '0;
              best_v_nxt = 1'b0;
            end else if (cnt_r == '0) begin
              od_nxt = pack(ST_NONE, 5'd0, 31'd0, 1'b0);
              ol_nxt = 1'b1;
              ov_nxt = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              // The removal held back from the previous scan is the final one.
              od_nxt = pack((op_r == OP_EXPIRE) ? ST_EXPIRED : ST_CANCELLED,
                            5'(pend_i_r), 31'd0, 1'b0);
              ol_nxt = 1'b1;
              ov_nxt = 1'b1;
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_EMIT: begin
        if (!ov_nxt) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      armed_r <= '0;
      ov_r <= 1'b0;
      lazy_r <= LAZY_RESET;
      rd_v_r <= 1'b0;
      cnt_r <= '0;
      best_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      armed_r <= armed_nxt;
      best_v_r <= best_v_nxt;
      rd_v_r <= (state_r == S_SCAN) && (idx_r < (SLOT_BITS+1)'(SLOTS));
      if (cfg_valid && cfg_ready) lazy_r <= cfg_data;
      if (in_tvalid && in_tready) cnt_r <= '0;
      else cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_i_r <= idx_r[SLOT_BITS-1:0];
    idx_r <= idx_nxt;
    best_i_r <= best_i_nxt;
    best_k_r <= best_k_nxt;
    best_c_r <= best_c_nxt;
    pend_i_r <= pend_i_nxt;
    od_r <= od_nxt;
    ol_r <= ol_nxt;
    if (in_tvalid && in_tready) begin
      op_r <= in_tdata[2:0];
      slot_r <= in_tdata[7:3];
      delay_r <= in_tdata[38:8];
      cok_r <= in_tdata[39];
      now_r <= in_tdata[71:40];
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !out_tvalid) else $error("result shown while idle");
  a_scan_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("held beat changed");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'(MAX_RESULTS)) else $error("too many removals");
`endif
endmodule

// ----- tb/tb_deadline_timer_table_top.sv -----
// Self-checking testbench of the deadline timer table: directed and random commands, scoreboard.
`timescale 1ns / 1ps

class dtt_scoreboard;
  bit         armed[dtt_pkg::SLOTS];
  logic [31:0] deadline[dtt_pkg::SLOTS];
  bit         cancelable[dtt_pkg::SLOTS];
  logic [15:0] lazy_ms;
  logic [40:0] pending[$];  // {last, no_timer, wait_ms, slot, status}
  int          mismatches;
  int          results_seen;

  function void clear_table();
    for (int i = 0; i < dtt_pkg::SLOTS; i++) armed[i] = 0;
    lazy_ms = dtt_pkg::LAZY_RESET;
  endfunction

  function void push_result(logic [2:0] st, logic [4:0] sl, logic [30:0] w,
                            bit nt, bit lst);
    pending.push_back({lst, nt, w, sl, st});
  endfunction

  // Armed slot with the soonest deadline relative to now, lowest slot on ties; -1 if none.
  function int soonest(logic [31:0] now);
    int best;
    logic [31:0] k;
    logic [31:0] bk;
    best = -1;
    bk = 0;
    for (int i = 0; i < dtt_pkg::SLOTS; i++)
      if (armed[i]) begin
        k = (deadline[i] - now) ^ 32'h8000_0000;
        if (best < 0 || k < bk) begin
          best = i;
          bk = k;
        end
      end
    return best;
  endfunction

  function void note_command(logic [71:0] d);
    logic [2:0]  op;
    logic [4:0]  sl;
    logic [30:0] dly;
    bit          cok;
    logic [31:0] now;
    logic [31:0] key;
    logic [31:0] diff;
    logic [31:0] mag;
    int          b;
    int          n;
    op = d[2:0];
    sl = d[7:3];
    dly = d[38:8];
    cok = d[39];
    now = d[71:40];
    case (op)
      dtt_pkg::OP_ADD: begin
        key = now + {1'b0, dly};
        cancelable[sl] = cok;
        if (armed[sl]) begin
          diff = key - deadline[sl];
          mag = diff[31] ? -diff : diff;
          if (mag < {16'd0, lazy_ms}) begin
            push_result(dtt_pkg::ST_KEPT, sl, 0, 0, 1);
            return;
          end
        end
        deadline[sl] = key;
        armed[sl] = 1;
        push_result(dtt_pkg::ST_ADDED, sl, 0, 0, 1);
      end
      dtt_pkg::OP_DELETE: begin
        if (armed[sl]) begin
          armed[sl] = 0;
          push_result(dtt_pkg::ST_DELETED, sl, 0, 0, 1);
        end else begin
          push_result(dtt_pkg::ST_NOT_ARMED, sl, 0, 0, 1);
        end
      end
      dtt_pkg::OP_FIND: begin
        b = soonest(now);
        if (b < 0) begin
          push_result(dtt_pkg::ST_WAIT, 0, 0, 1, 1);
        end else begin
          diff = deadline[b] - now;
          push_result(dtt_pkg::ST_WAIT, 0, diff[31] ? 31'd0 : diff[30:0], 0, 1);
        end
      end
      dtt_pkg::OP_EXPIRE, dtt_pkg::OP_CANCEL: begin
        n = 0;
        while (n < dtt_pkg::MAX_RESULTS) begin
          b = soonest(now);
          if (b < 0) break;
          diff = deadline[b] - now;
          if (op == dtt_pkg::OP_EXPIRE && diff != 0 && !diff[31]) break;
          if (op == dtt_pkg::OP_CANCEL && !cancelable[b]) break;
          armed[b] = 0;
          push_result(op == dtt_pkg::OP_EXPIRE ? dtt_pkg::ST_EXPIRED : dtt_pkg::ST_CANCELLED,
                      b[4:0], 0, 0, 0);
          n++;
        end
        if (n == 0) push_result(dtt_pkg::ST_NONE, 0, 0, 0, 1);
        else pending[$][40] = 1;
      end
      default: push_result(dtt_pkg::ST_NONE, 0, 0, 0, 1);
    endcase
  endfunction

  function void check_result(logic [39:0] d, logic lst);
    logic [40:0] exp_r;
    results_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h last %b", d, lst);
      return;
    end
    exp_r = pending.pop_front();
    if (exp_r !== {lst, d}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected st=%0d slot=%0d wait=%0d none=%b last=%b, got st=%0d slot=%0d wait=%0d none=%b last=%b",
                 exp_r[2:0], exp_r[7:3], exp_r[38:8], exp_r[39], exp_r[40],
                 d[2:0], d[7:3], d[38:8], d[39], lst);
    end
  endfunction
endclass

module tb_deadline_timer_table_top;
  import dtt_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  dtt_scoreboard timers = new();
  int  commands_sent;
  int  idle_cycles;
  bit  timed_out;
  logic [31:0] clock_ms;

  deadline_timer_table_top i_dut (.*);

  always #4 clk = ~clk;

  // Result side: before each beat it waits a random number of cycles with tready low.
  initial begin
    int w;
    @(negedge clk);
    forever begin
      w = $urandom_range(0, 4);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) timers.check_result(out_tdata, out_tlast);
    if (!rst_n || (out_tvalid && out_tready) || (in_tvalid && in_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk)
    if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired, %0d results outstanding", timers.pending.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end

  task automatic send_command(logic [2:0] op, logic [4:0] sl, logic [30:0] dly, bit cok,
                              logic [31:0] now, bit gaps = 1);
    @(negedge clk);
    if (gaps) repeat ($urandom_range(0, 4)) @(negedge clk);
    in_tdata <= {now, cok, dly, sl, op};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    timers.note_command({now, cok, dly, sl, op});
    commands_sent++;
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    while (timers.pending.size() != 0) @(posedge clk);
    repeat (3 * (SLOTS + 2) * 2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_lazy(logic [15:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timers.lazy_ms = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int count);
    int r;
    logic [30:0] dly;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      clock_ms += $urandom_range(0, 400);
      // Short delays keep expiry busy; occasional full-range ones hit every delay bit.
      dly = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1500));
      if (r < 40)
        send_command(OP_ADD, 5'($urandom_range(0, 31)), dly, 1'($urandom), clock_ms);
      else if (r < 52)
        send_command(OP_DELETE, 5'($urandom_range(0, 31)), 0, 0, clock_ms);
      else if (r < 65)
        send_command(OP_FIND, 5'($urandom), 31'($urandom), 1'($urandom), clock_ms);
      else if (r < 82)
        send_command(OP_EXPIRE, 5'($urandom), 31'($urandom), 1'($urandom), clock_ms);
      else if (r < 95)
        send_command(OP_CANCEL, 5'($urandom), 31'($urandom), 1'($urandom), clock_ms);
      else
        send_command(3'($urandom_range(5, 7)), 5'($urandom), 31'($urandom), 1'($urandom),
                     $urandom);
    end
  endtask

  initial begin
    timers.clear_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: empty table, full range fields, lazy keep, ties, wrap, bulk removal.
    send_command(OP_FIND, 0, 0, 0, 32'd0);
    send_command(OP_EXPIRE, 0, 0, 0, 32'd0);
    send_command(OP_CANCEL, 0, 0, 0, 32'd0);
    send_command(OP_DELETE, 5'd31, 0, 0, 32'd0);
    send_command(3'd7, 5'd31, 31'h7fff_ffff, 1, 32'hffff_ffff);
    send_command(OP_ADD, 5'd0, 31'h7fff_ffff, 1, 32'hffff_fff0);
    send_command(OP_ADD, 5'd0, 31'h7fff_ffff - 31'd100, 0, 32'hffff_fff0);
    send_command(OP_ADD, 5'd31, 31'd0, 1, 32'h8000_0000);
    send_command(OP_ADD, 5'd5, 31'd0, 1, 32'h8000_0000);
    send_command(OP_FIND, 0, 0, 0, 32'h8000_0000);
    send_command(OP_FIND, 0, 0, 0, 32'h8000_0010);
    send_command(OP_CANCEL, 0, 0, 0, 32'h8000_0000);
    send_command(OP_DELETE, 5'd0, 0, 0, 32'h8000_0000);
    send_command(OP_DELETE, 5'd0, 0, 0, 32'h8000_0000);
    for (int i = 0; i < SLOTS; i++)
      send_command(OP_ADD, 5'(i), 31'd10, 1'(i != 20), 32'd1000, 0);
    send_command(OP_FIND, 0, 0, 0, 32'd1000);
    send_command(OP_CANCEL, 0, 0, 0, 32'd1000);
    send_command(OP_EXPIRE, 0, 0, 0, 32'd5000);

    // Pause until the table has answered everything before moving on.
    drain();
    write_lazy(16'd0);
    clock_ms = $urandom;
    random_phase(100);
    write_lazy(16'hffff);
    random_phase(60);
    write_lazy(16'($urandom_range(1, 2000)));
    random_phase(110);
    // Refill completely so one expire removes all slots at once.
    for (int i = 0; i < SLOTS; i++) send_command(OP_ADD, 5'(i), 31'd1, 1, clock_ms + 5000);
    send_command(OP_EXPIRE, 0, 0, 0, clock_ms + 9000);

    drain();
    $display("Covered %0d commands (directed and random, lazy threshold 0, max, random)",
             commands_sent);
    $display("and checked %0d result beats under random gaps and back-pressure.",
             timers.results_seen);
    if (timers.mismatches == 0 && timers.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/dtt_pkg.sv
hdl/dtt_ram.sv
hdl/deadline_timer_table_top.sv
tb/tb_deadline_timer_table_top.sv
